/* sv/bxs_pkg.sv */
`default_nettype none

package bxs_pkg;

	localparam int unsigned VALUE_W = 8;

	typedef logic [VALUE_W-1:0] value_t;

	typedef enum logic {
		ST_LOAD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic insert;
		logic shift;
	} ctl_t;

endpackage

`default_nettype wire

/* sv/byte_exchange_sorter_core.sv */
// the first sorted beat is offered in the cycle after the last input beat is accepted
// one input beat per cycle while loading, one output beat per cycle
// while emitting and m_tready is high
// input is held off while a sorted run is being emitted
// reset clears all valid bits, the overflow flag and the state; cell data is not reset
`default_nettype none

module byte_exchange_sorter_core #(
	parameter int unsigned MAX_ITEMS = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // item_value
	input  wire logic       s_tlast,   // item_last
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // sorted_value
	output logic            m_tlast,   // sorted_last
	output logic            m_tuser    // items_dropped
);
	import bxs_pkg::*;

	state_t state_q, state_d;
	logic   overflow_q;
	ctl_t   ctl;

	logic   cell_valid [MAX_ITEMS];
	logic   cell_gt    [MAX_ITEMS];
	value_t cell_value [MAX_ITEMS];

	logic s_beat, m_beat, full, run_end;

	assign full    = cell_valid[MAX_ITEMS-1];
	assign s_beat  = s_tvalid && s_tready;
	assign m_beat  = m_tvalid && m_tready;
	assign run_end = !cell_valid[1];

	genvar i;
	generate
		for (i = 0; i < MAX_ITEMS; i++) begin : g_cell
			logic   p_valid, p_gt, n_valid;
			value_t p_value, n_value;
			if (i == 0) begin : g_first
				assign p_valid = 1'b1;
				assign p_gt    = 1'b0;
				assign p_value = '0;
			end else begin : g_mid
				assign p_valid = cell_valid[i-1];
				assign p_gt    = cell_gt[i-1];
				assign p_value = cell_value[i-1];
			end
			if (i == MAX_ITEMS - 1) begin : g_last
				assign n_valid = 1'b0;
				assign n_value = '0;
			end else begin : g_inner
				assign n_valid = cell_valid[i+1];
				assign n_value = cell_value[i+1];
			end
			bxs_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctl),
				.x          (s_tdata),
				.prev_valid (p_valid),
				.prev_gt    (p_gt),
				.prev_value (p_value),
				.next_valid (n_valid),
				.next_value (n_value),
				.valid      (cell_valid[i]),
				.gt         (cell_gt[i]),
				.value      (cell_value[i])
			);
		end
	endgenerate

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (s_beat && s_tlast) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (m_beat && run_end) begin
					state_d = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		s_tready   = 1'b0;
		m_tvalid   = 1'b0;
		ctl.insert = 1'b0;
		ctl.shift  = 1'b0;
		case (state_q)
			ST_LOAD: begin
				s_tready   = 1'b1;
				ctl.insert = s_beat && !full;
			end
			ST_EMIT: begin
				m_tvalid  = cell_valid[0];
				ctl.shift = m_beat;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	assign m_tdata = cell_value[0];
	assign m_tlast = run_end;
	assign m_tuser = overflow_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			overflow_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (s_beat && full) begin
				overflow_q <= 1'b1;
			end else if (m_beat && run_end) begin
				overflow_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

/* sv/bxs_cell.sv */
`default_nettype none

module bxs_cell (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire bxs_pkg::ctl_t    ctl,
	input  wire bxs_pkg::value_t  x,
	input  wire logic             prev_valid,
	input  wire logic             prev_gt,
	input  wire bxs_pkg::value_t  prev_value,
	input  wire logic             next_valid,
	input  wire bxs_pkg::value_t  next_value,
	output logic                  valid,
	output logic                  gt,
	output bxs_pkg::value_t       value
);
	import bxs_pkg::*;

	value_t value_q;
	logic   valid_q;

	// empty cells count as larger than anything
	assign gt    = !valid_q || ($signed(value_q) > $signed(x));
	assign valid = valid_q;
	assign value = value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.insert) begin
			valid_q <= prev_valid;
		end else if (ctl.shift) begin
			valid_q <= next_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.insert) begin
			if (gt) begin
				value_q <= prev_gt ? prev_value : x;
			end
		end else if (ctl.shift) begin
			value_q <= next_value;
		end
	end

endmodule

`default_nettype wire
